// ===== hw/rtl/hpj_pkg.sv =====
// ----------------------------------------------------------------------------
// hpj_pkg
// Widths, payload structs and the shared clip function of the homography
// pixel Jacobian pipeline.
// ----------------------------------------------------------------------------
package hpj_pkg;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // field widths
  localparam int COORD_BITS = 12;
  localparam int GRAD_BITS  = 16;
  localparam int CFG_W      = 32;
  localparam int CEN_W      = 16;
  localparam int OUT_W      = 48;
  localparam int ADDR_W     = 4;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_SCALE,
    REG_INV_SCALE,
    REG_CENTER_X,
    REG_CENTER_Y
  } reg_idx_t;

  // fixed-point formats: coordinates Q.4, outputs Q.8
  localparam int FRAC_IN = 4;
  localparam int QUP_W   = 4;

  // center offset u, v (signed Q.4) and its magnitude
  localparam int X4_W   = COORD_BITS + FRAC_IN;
  localparam int OFF_W  = max2(X4_W, CEN_W) + 1;
  localparam int OFFM_W = OFF_W - 1;

  // gradient times offset, and sums of two such products
  localparam int GU_W  = GRAD_BITS + OFF_W;
  localparam int T_W   = GU_W + 1;
  localparam int LIN_W = T_W + QUP_W;

  // gradient times reciprocal (Q16.16), rounded by 8 bits
  localparam int RCP_P_W = GRAD_BITS + CFG_W;
  localparam int RCP_SH  = 8;
  localparam int RCP_R_W = RCP_P_W - RCP_SH;

  // cubic terms: (scale * |u|) * |t|, split into four partial products
  localparam int SA_W    = CFG_W + OFFM_W;
  localparam int SAL_W   = SA_W / 2;
  localparam int SAH_W   = SA_W - SAL_W;
  localparam int TL_W    = T_W / 2;
  localparam int TH_W    = T_W - TL_W;
  localparam int CP_W    = SA_W + T_W;
  localparam int CUB_SH  = 30;
  localparam int CUB_R_W = CP_W - CUB_SH;

  localparam int CLIP_W = max2(max2(LIN_W, RCP_R_W), max2(CUB_R_W, OUT_W + 1));

  typedef struct packed {
    logic en_a;
    logic en_b;
  } stage_en_t;

  typedef struct packed {
    logic                        neg;
    logic [T_W-1:0]              mag;
  } lin_t;

  typedef struct packed {
    logic                        neg;
    logic [RCP_R_W-1:0]          mag;
  } rcp_t;

  typedef struct packed {
    logic                        neg;
    logic [SAL_W+TL_W-1:0]       ll;
    logic [SAL_W+TH_W-1:0]       lh;
    logic [SAH_W+TL_W-1:0]       hl;
    logic [SAH_W+TH_W-1:0]       hh;
  } part_t;

  // products after the second stage
  typedef struct packed {
    logic signed [GU_W-1:0]      gxu;
    logic signed [GU_W-1:0]      gyu;
    logic signed [GU_W-1:0]      gxv;
    logic signed [GU_W-1:0]      gyv;
    logic [RCP_P_W-1:0]          rx;
    logic [RCP_P_W-1:0]          ry;
    logic                        nx;
    logic                        ny;
    logic [SA_W-1:0]             sau;
    logic [SA_W-1:0]             sav;
    logic                        nu;
    logic                        nv;
  } geo_t;

  // terms after the fourth stage
  typedef struct packed {
    lin_t                        e2;
    lin_t                        e3;
    lin_t                        e4;
    lin_t                        e5;
    rcp_t                        r0;
    rcp_t                        r1;
    part_t                       cu;
    part_t                       cv;
  } mix_t;

  typedef struct packed {
    logic [OUT_W-1:0]            val;
    logic                        sat;
  } clip_t;

  // sign and magnitude to a saturated two's complement output element
  function automatic clip_t clip(input logic neg, input logic [CLIP_W-1:0] mag);
    logic [CLIP_W-1:0] lim;
    logic [OUT_W-1:0]  m;
    clip_t             r;
    lim   = neg ? (CLIP_W'(1) << (OUT_W - 1))
                : ((CLIP_W'(1) << (OUT_W - 1)) - CLIP_W'(1));
    r.sat = (mag > lim);
    m     = r.sat ? lim[OUT_W-1:0] : mag[OUT_W-1:0];
    r.val = neg ? (~m + 1'b1) : m;
    return r;
  endfunction

endpackage

// ===== hw/rtl/hpj_geom.sv =====
// ----------------------------------------------------------------------------
// hpj_geom
// Stages one and two: center offsets, then gradient products, reciprocal
// products and scale times offset magnitude.
// ----------------------------------------------------------------------------
module hpj_geom (
  input  logic                                clk,
  input  hpj_pkg::stage_en_t                  en,
  input  logic [hpj_pkg::COORD_BITS-1:0]      x_pos,
  input  logic [hpj_pkg::COORD_BITS-1:0]      y_pos,
  input  logic signed [hpj_pkg::GRAD_BITS-1:0] grad_x,
  input  logic signed [hpj_pkg::GRAD_BITS-1:0] grad_y,
  input  logic [hpj_pkg::CFG_W-1:0]           scale,
  input  logic [hpj_pkg::CFG_W-1:0]           inv_scale,
  input  logic [hpj_pkg::CEN_W-1:0]           center_x,
  input  logic [hpj_pkg::CEN_W-1:0]           center_y,
  output hpj_pkg::geo_t                       s2
);

  localparam int OFF_W  = hpj_pkg::OFF_W;
  localparam int OFFM_W = hpj_pkg::OFFM_W;
  localparam int GB     = hpj_pkg::GRAD_BITS;
  localparam int GU_W   = hpj_pkg::GU_W;
  localparam int RP_W   = hpj_pkg::RCP_P_W;
  localparam int SA_W   = hpj_pkg::SA_W;

  logic signed [OFF_W-1:0] u_next, v_next;
  logic signed [OFF_W-1:0] u_a, v_a;
  logic signed [GB-1:0]    gx_a, gy_a;
  logic [GB-1:0]           gx_mag, gy_mag;
  logic [OFF_W-1:0]        u_abs, v_abs;

  assign u_next = OFF_W'(center_x) - OFF_W'({x_pos, {hpj_pkg::FRAC_IN{1'b0}}});
  assign v_next = OFF_W'(center_y) - OFF_W'({y_pos, {hpj_pkg::FRAC_IN{1'b0}}});

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      u_a  <= u_next;
      v_a  <= v_next;
      gx_a <= grad_x;
      gy_a <= grad_y;
    end
  end

  assign gx_mag = gx_a[GB-1] ? -gx_a : gx_a;
  assign gy_mag = gy_a[GB-1] ? -gy_a : gy_a;
  assign u_abs  = u_a[OFF_W-1] ? -u_a : u_a;
  assign v_abs  = v_a[OFF_W-1] ? -v_a : v_a;

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      s2.gxu <= GU_W'(gx_a) * GU_W'(u_a);
      s2.gyu <= GU_W'(gy_a) * GU_W'(u_a);
      s2.gxv <= GU_W'(gx_a) * GU_W'(v_a);
      s2.gyv <= GU_W'(gy_a) * GU_W'(v_a);
      s2.rx  <= RP_W'(gx_mag) * RP_W'(inv_scale);
      s2.ry  <= RP_W'(gy_mag) * RP_W'(inv_scale);
      s2.nx  <= gx_a[GB-1];
      s2.ny  <= gy_a[GB-1];
      s2.sau <= SA_W'(scale) * SA_W'(u_abs[OFFM_W-1:0]);
      s2.sav <= SA_W'(scale) * SA_W'(v_abs[OFFM_W-1:0]);
      s2.nu  <= u_a[OFF_W-1];
      s2.nv  <= v_a[OFF_W-1];
    end
  end

endmodule

// ===== hw/rtl/hpj_mix.sv =====
// ----------------------------------------------------------------------------
// hpj_mix
// Stages three and four: linear sums, reciprocal rounding, then the partial
// products of the two cubic terms.
// ----------------------------------------------------------------------------
module hpj_mix (
  input  logic               clk,
  input  hpj_pkg::stage_en_t en,
  input  hpj_pkg::geo_t      s2,
  output hpj_pkg::mix_t      s4
);

  localparam int T_W   = hpj_pkg::T_W;
  localparam int GU_W  = hpj_pkg::GU_W;
  localparam int RP_W  = hpj_pkg::RCP_P_W;
  localparam int RSH   = hpj_pkg::RCP_SH;
  localparam int SA_W  = hpj_pkg::SA_W;
  localparam int SAL_W = hpj_pkg::SAL_W;
  localparam int TL_W  = hpj_pkg::TL_W;

  function automatic hpj_pkg::lin_t to_lin(input logic [T_W-1:0] e);
    hpj_pkg::lin_t r;
    r.neg = e[T_W-1];
    r.mag = r.neg ? (~e + 1'b1) : e;
    return r;
  endfunction

  logic signed [T_W-1:0] gxu_w, gyu_w, gxv_w, gyv_w;
  logic signed [T_W-1:0] t_sum;
  logic [RP_W-1:0]       rx_rnd, ry_rnd;
  hpj_pkg::lin_t         t_lin;

  hpj_pkg::lin_t         c_e2, c_e3, c_e4, c_e5;
  hpj_pkg::rcp_t         c_r0, c_r1;
  logic [T_W-1:0]        c_tmag;
  logic                  c_cnu, c_cnv;
  logic [SA_W-1:0]       c_sau, c_sav;

  assign gxu_w  = {s2.gxu[GU_W-1], s2.gxu};
  assign gyu_w  = {s2.gyu[GU_W-1], s2.gyu};
  assign gxv_w  = {s2.gxv[GU_W-1], s2.gxv};
  assign gyv_w  = {s2.gyv[GU_W-1], s2.gyv};
  assign t_sum  = gxu_w + gyv_w;
  assign t_lin  = to_lin(t_sum);
  assign rx_rnd = s2.rx + (RP_W'(1) << (RSH - 1));
  assign ry_rnd = s2.ry + (RP_W'(1) << (RSH - 1));

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      c_e2     <= to_lin(gyu_w - gxv_w);
      c_e3     <= to_lin(-t_sum);
      c_e4     <= to_lin(gyv_w - gxu_w);
      c_e5     <= to_lin(-gxv_w);
      c_r0.neg <= s2.nx;
      c_r0.mag <= rx_rnd[RP_W-1:RSH];
      c_r1.neg <= s2.ny;
      c_r1.mag <= ry_rnd[RP_W-1:RSH];
      c_tmag   <= t_lin.mag;
      c_cnu    <= (s2.nu == t_lin.neg);
      c_cnv    <= (s2.nv == t_lin.neg);
      c_sau    <= s2.sau;
      c_sav    <= s2.sav;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      s4.e2     <= c_e2;
      s4.e3     <= c_e3;
      s4.e4     <= c_e4;
      s4.e5     <= c_e5;
      s4.r0     <= c_r0;
      s4.r1     <= c_r1;
      s4.cu.neg <= c_cnu;
      s4.cu.ll  <= c_sau[SAL_W-1:0]    * c_tmag[TL_W-1:0];
      s4.cu.lh  <= c_sau[SAL_W-1:0]    * c_tmag[T_W-1:TL_W];
      s4.cu.hl  <= c_sau[SA_W-1:SAL_W] * c_tmag[TL_W-1:0];
      s4.cu.hh  <= c_sau[SA_W-1:SAL_W] * c_tmag[T_W-1:TL_W];
      s4.cv.neg <= c_cnv;
      s4.cv.ll  <= c_sav[SAL_W-1:0]    * c_tmag[TL_W-1:0];
      s4.cv.lh  <= c_sav[SAL_W-1:0]    * c_tmag[T_W-1:TL_W];
      s4.cv.hl  <= c_sav[SA_W-1:SAL_W] * c_tmag[TL_W-1:0];
      s4.cv.hh  <= c_sav[SA_W-1:SAL_W] * c_tmag[T_W-1:TL_W];
    end
  end

endmodule

// ===== hw/rtl/hpj_out.sv =====
// ----------------------------------------------------------------------------
// hpj_out
// Stages five and six: cubic partial sum with rounding, then saturation of
// all eight elements into the output register.
// ----------------------------------------------------------------------------
module hpj_out (
  input  logic                             clk,
  input  hpj_pkg::stage_en_t               en,
  input  hpj_pkg::mix_t                    s4,
  output logic signed [hpj_pkg::OUT_W-1:0] jac0,
  output logic signed [hpj_pkg::OUT_W-1:0] jac1,
  output logic signed [hpj_pkg::OUT_W-1:0] jac2,
  output logic signed [hpj_pkg::OUT_W-1:0] jac3,
  output logic signed [hpj_pkg::OUT_W-1:0] jac4,
  output logic signed [hpj_pkg::OUT_W-1:0] jac5,
  output logic signed [hpj_pkg::OUT_W-1:0] jac6,
  output logic signed [hpj_pkg::OUT_W-1:0] jac7,
  output logic                             saturated
);

  localparam int CP_W   = hpj_pkg::CP_W;
  localparam int CSH    = hpj_pkg::CUB_SH;
  localparam int TL_W   = hpj_pkg::TL_W;
  localparam int SAL_W  = hpj_pkg::SAL_W;
  localparam int CLIP_W = hpj_pkg::CLIP_W;
  localparam int QUP_W  = hpj_pkg::QUP_W;

  typedef struct packed {
    logic                          neg;
    logic [hpj_pkg::CUB_R_W-1:0]   mag;
  } cub_t;

  function automatic logic [CP_W-1:0] cub_sum(input hpj_pkg::part_t p);
    return CP_W'(p.ll) + (CP_W'(p.lh) << TL_W) + (CP_W'(p.hl) << SAL_W)
         + (CP_W'(p.hh) << (SAL_W + TL_W)) + (CP_W'(1) << (CSH - 1));
  endfunction

  function automatic logic [CLIP_W-1:0] lin_mag(input hpj_pkg::lin_t e);
    return CLIP_W'({e.mag, {QUP_W{1'b0}}});
  endfunction

  logic [CP_W-1:0]  pu, pv;
  cub_t             e_cu, e_cv;
  hpj_pkg::lin_t    e_e2, e_e3, e_e4, e_e5;
  hpj_pkg::rcp_t    e_r0, e_r1;
  hpj_pkg::clip_t   k0, k1, k2, k3, k4, k5, k6, k7;

  assign pu = cub_sum(s4.cu);
  assign pv = cub_sum(s4.cv);

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      e_cu.neg <= s4.cu.neg;
      e_cu.mag <= pu[CP_W-1:CSH];
      e_cv.neg <= s4.cv.neg;
      e_cv.mag <= pv[CP_W-1:CSH];
      e_e2     <= s4.e2;
      e_e3     <= s4.e3;
      e_e4     <= s4.e4;
      e_e5     <= s4.e5;
      e_r0     <= s4.r0;
      e_r1     <= s4.r1;
    end
  end

  assign k0 = hpj_pkg::clip(e_r0.neg, CLIP_W'(e_r0.mag));
  assign k1 = hpj_pkg::clip(e_r1.neg, CLIP_W'(e_r1.mag));
  assign k2 = hpj_pkg::clip(e_e2.neg, lin_mag(e_e2));
  assign k3 = hpj_pkg::clip(e_e3.neg, lin_mag(e_e3));
  assign k4 = hpj_pkg::clip(e_e4.neg, lin_mag(e_e4));
  assign k5 = hpj_pkg::clip(e_e5.neg, lin_mag(e_e5));
  assign k6 = hpj_pkg::clip(e_cu.neg, CLIP_W'(e_cu.mag));
  assign k7 = hpj_pkg::clip(e_cv.neg, CLIP_W'(e_cv.mag));

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      jac0      <= k0.val;
      jac1      <= k1.val;
      jac2      <= k2.val;
      jac3      <= k3.val;
      jac4      <= k4.val;
      jac5      <= k5.val;
      jac6      <= k6.val;
      jac7      <= k7.val;
      saturated <= k0.sat | k1.sat | k2.sat | k3.sat
                 | k4.sat | k5.sat | k6.sat | k7.sat;
    end
  end

endmodule

// ===== hw/rtl/homography_pixel_jacobian_core.sv =====
// ----------------------------------------------------------------------------
// homography_pixel_jacobian_core
// Per-pixel Jacobian row of a normalized homography: eight signed Q.8
// elements from pixel position and image gradients, with a saturation flag.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_ready    | x_pos, y_pos, grad_x, grad_y
//  out      | out_valid / out_ready  | jac0 .. jac7, saturated
//  config   | APB psel/penable/...   | scale, inv_scale, center_x, center_y
//
// One item enters per cycle while in_ready is high; each item then passes
// every register stage in turn up to out_valid (offsets, products, sums, cubic
// partial products, cubic sum, saturation into the output register).
// Each stage holds its own valid bit; a stage loads when it is empty or when
// the stage after it moves, so a stall on out fills bubbles first and then
// holds every item in place. in_ready follows that chain.
// rst clears the valid bits and restores the register reset values.
//
module homography_pixel_jacobian_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [hpj_pkg::COORD_BITS-1:0]       x_pos,
  input  logic [hpj_pkg::COORD_BITS-1:0]       y_pos,
  input  logic signed [hpj_pkg::GRAD_BITS-1:0] grad_x,
  input  logic signed [hpj_pkg::GRAD_BITS-1:0] grad_y,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac0,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac1,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac2,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac3,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac4,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac5,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac6,
  output logic signed [hpj_pkg::OUT_W-1:0]     jac7,
  output logic                                 saturated,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hpj_pkg::ADDR_W-1:0]           paddr,
  input  logic [hpj_pkg::CFG_W-1:0]            pwdata,
  output logic [hpj_pkg::CFG_W-1:0]            prdata,
  output logic                                 pready
);

  localparam int STAGES = 6;
  localparam int CFG_W  = hpj_pkg::CFG_W;
  localparam int CEN_W  = hpj_pkg::CEN_W;

  localparam logic [CFG_W-1:0] SCALE_RST = 32'h4000_0000;  // 1.0 in Q2.30
  localparam logic [CFG_W-1:0] INV_RST   = 32'h0001_0000;  // 1.0 in Q16.16

  logic [CFG_W-1:0]  scale, inv_scale;
  logic [CEN_W-1:0]  center_x, center_y;
  hpj_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] stg_en;

  hpj_pkg::stage_en_t en_geom, en_mix, en_out;
  hpj_pkg::geo_t      s2;
  hpj_pkg::mix_t      s4;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = hpj_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RST;
      inv_scale <= INV_RST;
      center_x  <= '0;
      center_y  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        hpj_pkg::REG_SCALE:     scale     <= pwdata;
        hpj_pkg::REG_INV_SCALE: inv_scale <= pwdata;
        hpj_pkg::REG_CENTER_X:  center_x  <= pwdata[CEN_W-1:0];
        hpj_pkg::REG_CENTER_Y:  center_y  <= pwdata[CEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hpj_pkg::REG_SCALE:     prdata = scale;
      hpj_pkg::REG_INV_SCALE: prdata = inv_scale;
      hpj_pkg::REG_CENTER_X:  prdata = CFG_W'(center_x);
      hpj_pkg::REG_CENTER_Y:  prdata = CFG_W'(center_y);
    endcase
  end

  // ------------------------------------------------------- stage control
  // A stage advances when it is empty or the next stage advances.
  always_comb begin
    stg_en[STAGES-1] = ~vld[STAGES-1] | out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stg_en[k] = ~vld[k] | stg_en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stg_en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (stg_en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld[STAGES-1];

  assign en_geom = '{en_a: stg_en[0], en_b: stg_en[1]};
  assign en_mix  = '{en_a: stg_en[2], en_b: stg_en[3]};
  assign en_out  = '{en_a: stg_en[4], en_b: stg_en[5]};

  // -------------------------------------------------------------- datapath
  // offsets and products
  hpj_geom u_geom (
    .clk       (clk),
    .en        (en_geom),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .grad_x    (grad_x),
    .grad_y    (grad_y),
    .scale     (scale),
    .inv_scale (inv_scale),
    .center_x  (center_x),
    .center_y  (center_y),
    .s2        (s2)
  );

  // linear sums, reciprocal rounding, cubic partial products
  hpj_mix u_mix (
    .clk (clk),
    .en  (en_mix),
    .s2  (s2),
    .s4  (s4)
  );

  // cubic rounding and saturation into the output register
  hpj_out u_out (
    .clk       (clk),
    .en        (en_out),
    .s4        (s4),
    .jac0      (jac0),
    .jac1      (jac1),
    .jac2      (jac2),
    .jac3      (jac3),
    .jac4      (jac4),
    .jac5      (jac5),
    .jac6      (jac6),
    .jac7      (jac7),
    .saturated (saturated)
  );

endmodule
